// ----- src/spq_pkg.sv -----
// Shared types and codes for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        RES_INSERTED = 2'd0,
        RES_REMOVED  = 2'd1,
        RES_EMPTY    = 2'd2,
        RES_FULL     = 2'd3
    } res_status_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] item_value;
        logic signed [15:0] item_priority;
    } req_word_t;

    typedef struct packed {
        res_status_t        status;
        logic signed [31:0] out_value;
        logic signed [15:0] out_priority;
        logic [4:0]         occupancy;
    } rsp_word_t;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_HOLD
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic        op_en;
        res_status_t status;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
    } dp_stat_t;

endpackage

// ----- src/stable_priority_queue.sv -----
// Top level of the stable priority queue: controller, datapath and checks.
// Latency: a result word is offered the cycle after its request word is accepted.
// Throughput: one word per cycle while no result waits under rsp_stall; the parallel compare-and-shift
//   over all cells completes an insert or a remove by updating every cell together.
// Reset (rst_n low, asynchronous): the queue empties and no result is held;
//   cell contents are left as they are and are never read before being written.
`timescale 1ns / 1ps

module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [CNT_W-1:0] count;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_kind  (req.kind),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .item_value    (req.item_value),
        .item_priority (req.item_priority),
        .stat          (stat),
        .count         (count),
        .rsp           (rsp)
    );

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_remove_count : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op_en && cmd.status == RES_REMOVED |=> count == $past(count) - 1'b1)
        else $error("remove did not drop one entry");

    a_insert_count : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op_en && cmd.status == RES_INSERTED |=> count == $past(count) + 1'b1)
        else $error("insert did not add one entry");

    a_empty_word : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == RES_EMPTY |-> rsp.out_value == '0 &&
            rsp.out_priority == '0 && rsp.occupancy == '0)
        else $error("empty result carries data");

    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("input stalled without a waiting result");

endmodule

// ----- src/spq_ctrl.sv -----
// Handshake controller: accepts a word and holds its result until taken.
`timescale 1ns / 1ps

module spq_ctrl
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  kind_t    req_kind,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTRL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        req_stall  = 1'b0;
        rsp_valid  = 1'b0;
        state_next = state_reg;
        case (state_reg)
            CTRL_IDLE:
            begin
                req_stall = 1'b0;
                rsp_valid = 1'b0;
            end
            CTRL_HOLD:
            begin
                // a waiting result blocks the input only while it is stalled
                req_stall = rsp_stall;
                rsp_valid = 1'b1;
                if (!rsp_stall)
                begin
                    state_next = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase

        accept = req_valid && !req_stall;
        if (accept)
        begin
            state_next = CTRL_HOLD;
        end

        cmd.op_en = accept;
        if (req_kind == KIND_INSERT)
        begin
            cmd.status = stat.full ? RES_FULL : RES_INSERTED;
        end
        else
        begin
            cmd.status = stat.empty ? RES_EMPTY : RES_REMOVED;
        end
    end

endmodule

// ----- src/spq_datapath.sv -----
// Sorted entry cells with parallel compare-and-shift, entry count and result register.
`timescale 1ns / 1ps

module spq_datapath
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  logic signed [31:0] item_value,
    input  logic signed [15:0] item_priority,
    output dp_stat_t           stat,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
    output rsp_word_t          rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic signed [31:0] value_reg [QUEUE_DEPTH];
    logic signed [15:0] prio_reg  [QUEUE_DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    rsp_word_t          rsp_reg;
    rsp_word_t          rsp_next;
    logic [QUEUE_DEPTH-1:0] ahead;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign count      = count_reg;
    assign rsp        = rsp_reg;

    // Cells that stay in front of a new entry: valid and priority at least as high
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            ahead[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] >= item_priority);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.status == RES_INSERTED)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.status == RES_REMOVED)
        begin
            count_next = count_reg - 1'b1;
        end

        rsp_next.status       = cmd.status;
        rsp_next.out_value    = '0;
        rsp_next.out_priority = '0;
        rsp_next.occupancy    = 5'(count_next);
        if (cmd.status == RES_REMOVED)
        begin
            rsp_next.out_value    = value_reg[0];
            rsp_next.out_priority = prio_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.op_en)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op_en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (cmd.op_en && cmd.status == RES_INSERTED && !ahead[g])
            begin
                if (g == 0)
                begin
                    value_reg[g] <= item_value;
                    prio_reg[g]  <= item_priority;
                end
                else if (ahead[(g == 0) ? 0 : g - 1])
                begin
                    value_reg[g] <= item_value;
                    prio_reg[g]  <= item_priority;
                end
                else
                begin
                    // shift back one place behind the new entry
                    value_reg[g] <= value_reg[(g == 0) ? 0 : g - 1];
                    prio_reg[g]  <= prio_reg[(g == 0) ? 0 : g - 1];
                end
            end
            else if (cmd.op_en && cmd.status == RES_REMOVED && g < QUEUE_DEPTH - 1)
            begin
                // advance towards the head
                value_reg[g] <= value_reg[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                prio_reg[g]  <= prio_reg[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
            end
        end
    end

endmodule

// ----- dv/tb_stable_priority_queue.sv -----
// Self-checking testbench for the stable priority queue: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_stable_priority_queue;
    import spq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int RANDOM_WORDS   = 1600;
    localparam int IDLE_LIMIT     = 5000;
    localparam int MAX_REPORTS    = 10;

    typedef enum {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    typedef struct {
        req_word_t word;
        bit        typed;
        rsp_word_t result;
    } directed_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;

    // Predictor state: sorted by descending priority, ties in arrival order
    logic signed [31:0] model_value [DEPTH];
    logic signed [15:0] model_prio  [DEPTH];
    int                 model_count = 0;

    rsp_word_t     pending_results [$];
    directed_row_t directed_rows [$];
    int            mismatches = 0;
    int            idle_cycles = 0;
    int            burst_left = 1;
    stall_mode_t   stall_mode = STALL_NONE;
    int            stall_left = 0;

    stable_priority_queue #(.QUEUE_DEPTH(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic rsp_word_t queue_apply(req_word_t w);
        rsp_word_t r;
        int        pos;
        r = '0;
        if (w.kind == KIND_INSERT)
        begin
            if (model_count >= DEPTH)
            begin
                r.status = RES_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < model_count && model_prio[pos] >= w.item_priority)
                    pos++;
                for (int i = model_count; i > pos; i--)
                begin
                    model_value[i] = model_value[i - 1];
                    model_prio[i]  = model_prio[i - 1];
                end
                model_value[pos] = w.item_value;
                model_prio[pos]  = w.item_priority;
                model_count++;
                r.status = RES_INSERTED;
            end
        end
        else if (model_count == 0)
        begin
            r.status = RES_EMPTY;
        end
        else
        begin
            r.status       = RES_REMOVED;
            r.out_value    = model_value[0];
            r.out_priority = model_prio[0];
            for (int i = 1; i < model_count; i++)
            begin
                model_value[i - 1] = model_value[i];
                model_prio[i - 1]  = model_prio[i];
            end
            model_count--;
        end
        r.occupancy = 5'(model_count);
        return r;
    endfunction

    function automatic void add_row(kind_t k, logic [31:0] v, logic [15:0] p, bit typed,
                                    rsp_word_t r);
        directed_row_t row;
        row.word.kind          = k;
        row.word.item_value    = v;
        row.word.item_priority = p;
        row.typed              = typed;
        row.result             = r;
        directed_rows.push_back(row);
    endfunction

    function automatic req_word_t random_word(int insert_pct, int prio_mode);
        req_word_t w;
        int        pick;
        w.kind       = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
        w.item_value = $urandom;
        pick         = $urandom_range(0, 4);
        case (prio_mode)
            0: w.item_priority = 16'(pick - 2);
            1: w.item_priority = 16'($urandom);
            default:
            begin
                case (pick)
                    0: w.item_priority = 16'h7fff;
                    1: w.item_priority = 16'h8000;
                    2: w.item_priority = 16'hffff;
                    3: w.item_priority = 16'h0001;
                    default: w.item_priority = 16'h0000;
                endcase
            end
        endcase
        return w;
    endfunction

    // Offer one word, hold it until taken, then note what should come back.
    task automatic send_word(input req_word_t w, input bit typed, input rsp_word_t typed_rsp);
        rsp_word_t predicted;
        int        gap;
        req       <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        predicted = queue_apply(w);
        pending_results.push_back(typed ? typed_rsp : predicted);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
    endtask

    task automatic wait_drained;
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver stall pattern
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 7);
            default:        rsp_stall <= ((stall_left % 5) < 2);
        endcase
    end

    // Result checker
    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR %0t: unexpected result word status=%s value=%0d prio=%0d occ=%0d",
                             $realtime, rsp.status.name(), rsp.out_value, rsp.out_priority,
                             rsp.occupancy);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status || rsp.out_value !== want.out_value ||
                    rsp.out_priority !== want.out_priority ||
                    rsp.occupancy !== want.occupancy)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("ERROR %0t: expected status=%s value=%0d prio=%0d occ=%0d",
                                 $realtime, want.status.name(), want.out_value,
                                 want.out_priority, want.occupancy);
                        $display("         got      status=%s value=%0d prio=%0d occ=%0d",
                                 rsp.status.name(), rsp.out_value, rsp.out_priority,
                                 rsp.occupancy);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        req_word_t word;
        int        sent;
        int        phase_left;
        int        insert_pct;
        int        prio_mode;
        bit        paused;

        // Directed table
        add_row(KIND_REMOVE, 32'h0, 16'h0, 1'b1, '{RES_EMPTY, 32'sd0, 16'sd0, 5'd0});
        add_row(KIND_INSERT, 32'h7fffffff, 16'h7fff, 1'b1,
                '{RES_INSERTED, 32'sd0, 16'sd0, 5'd1});
        add_row(KIND_INSERT, 32'h80000000, 16'h8000, 1'b1,
                '{RES_INSERTED, 32'sd0, 16'sd0, 5'd2});
        add_row(KIND_INSERT, 32'hffffffff, 16'h0000, 1'b0, '0);
        // equal priority: must leave after the previous word
        add_row(KIND_INSERT, 32'h00000005, 16'h0000, 1'b0, '0);
        // item fields on a remove are ignored
        add_row(KIND_REMOVE, 32'hffffffff, 16'hffff, 1'b1,
                '{RES_REMOVED, 32'sh7fffffff, 16'sh7fff, 5'd3});
        for (int i = 0; i < DEPTH - 3; i++)
            add_row(KIND_INSERT, 32'(i * 32'h01010101), 16'((i % 4) - 1), 1'b0, '0);
        add_row(KIND_INSERT, 32'h12345678, 16'h7fff, 1'b1,
                '{RES_FULL, 32'sd0, 16'sd0, 5'(DEPTH)});
        for (int i = 0; i < 3; i++)
            add_row(KIND_REMOVE, 32'h0, 16'h0, 1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed,
                      directed_rows[i].result);
        wait_drained();

        // Random phases that lean towards filling, draining or churning
        sent       = 0;
        phase_left = 0;
        insert_pct = 50;
        prio_mode  = 0;
        paused     = 1'b0;
        while (sent < RANDOM_WORDS)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 4))
                    0: insert_pct = 80;
                    1: insert_pct = 20;
                    2: insert_pct = 95;
                    3: insert_pct = 5;
                    default: insert_pct = 50;
                endcase
                prio_mode  = $urandom_range(0, 2);
                phase_left = $urandom_range(10, 60);
            end
            if (!paused && sent >= RANDOM_WORDS / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            word = random_word(insert_pct, prio_mode);
            send_word(word, 1'b0, '0);
            sent++;
            phase_left--;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/stable_priority_queue.sv
dv/tb_stable_priority_queue.sv
